// ----- design/spq_pkg.sv -----
// Shared types, constants and helpers for the stable priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FN_INSERT  = 2'd0,
    FN_DEQUEUE = 2'd1,
    FN_DELETE  = 2'd2,
    FN_FIND    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [31:0]        tag;
    logic signed [15:0] prio;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        out_tag;
    logic signed [15:0] out_prio;
    logic [4:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic               hole;
    logic [31:0]        tag;
    logic signed [15:0] prio;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '0;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DEQUEUE,
    OP_MARK,
    OP_PURGE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [31:0]        tag;
    logic signed [15:0] prio;
  } cell_cmd_t;

  typedef struct packed {
    logic               ge;
    logic               match;
    logic               extra;
    logic [31:0]        sel_tag;
    logic signed [15:0] sel_prio;
  } cell_stat_t;

  typedef struct packed {
    logic seen;
    logic found;
  } chain_t;

  typedef enum logic {
    S_IDLE,
    S_PURGE
  } state_t;

  function automatic logic [4:0] occ_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] w;
    w = {5'b0, c};
    return w[4:0];
  endfunction

endpackage

// ----- design/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  entry_t     left,
  input  logic       left_ge,
  input  entry_t     right,
  input  chain_t     chain_in,
  output entry_t     ent,
  output cell_stat_t stat,
  output chain_t     chain_out
);

  entry_t ent_next;
  logic   first;

  always_comb begin
    stat.ge    = ent.valid && (ent.prio >= cmd.prio);
    stat.match = ent.valid && !ent.hole && (ent.tag == cmd.tag);
    stat.extra = ent.hole && chain_in.seen;
    first      = stat.match && !chain_in.found;
    stat.sel_tag  = first ? ent.tag : '0;
    stat.sel_prio = first ? ent.prio : '0;
    chain_out.found = chain_in.found | stat.match;
    chain_out.seen  = chain_in.seen | ent.hole;
  end

  always_comb begin
    ent_next = ent;
    unique case (cmd.op)
      OP_HOLD: ent_next = ent;
      OP_INSERT: begin
        if (stat.ge) begin
          ent_next = ent;
        end else if (left_ge) begin
          ent_next = '{valid: 1'b1, hole: 1'b0, tag: cmd.tag, prio: cmd.prio};
        end else begin
          ent_next = left;
        end
      end
      OP_DEQUEUE: ent_next = right;
      OP_MARK: ent_next.hole = stat.match;
      OP_PURGE: begin
        if (chain_in.seen || ent.hole) begin
          ent_next = right;
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= EMPTY_ENTRY;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

// ----- design/stable_priority_queue_unit.sv -----
// Stable priority queue: a sorted chain of slots with a request and a response channel.
//
// Requests arrive on req (req_valid / req_stall) and carry func, tag and prio.
// Every request yields exactly one response on rsp (rsp_valid / rsp_stall)
// with status, out_tag, out_prio and occupancy.
// Insert, dequeue and find act on all slots at once; the response is
// registered in the response register, or in the skid entry under rsp_stall.
// Delete by tag marks every matching slot, then squeezes one marked slot out
// of the chain per cycle, the response following the last squeeze. Deletes
// that find nothing or an empty queue answer from the idle state without
// a squeeze.
// Throughput: one request per cycle for insert, dequeue and find while the
// skid entry is empty; the chain's single-step shift per cycle sets the delete time.
// The response register has a skid entry behind it, so one more request is
// taken while a response waits under rsp_stall; req_stall rises once both
// hold a response or while a delete is squeezing.
// Reset empties the queue (all slots invalid, count zero) and drops any
// pending responses.
module stable_priority_queue_unit import spq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  cell_cmd_t        cmd;
  entry_t           ent   [QUEUE_DEPTH];
  cell_stat_t       stat  [QUEUE_DEPTH];
  chain_t           chain [QUEUE_DEPTH+1];
  logic             accept;
  logic             full;
  logic             empty;
  logic             any_match;
  logic             extra_any;
  logic [31:0]      sel_tag;
  logic [15:0]      sel_prio;
  logic             wr;
  rsp_t             res;
  logic             skid_valid;
  rsp_t             skid;
  logic             rsp_free;

  assign req_stall = (state != S_IDLE) || skid_valid;
  assign accept    = req_valid && !req_stall;
  assign full      = ent[QUEUE_DEPTH-1].valid;
  assign empty     = !ent[0].valid;
  assign chain[0]  = '{seen: 1'b0, found: 1'b0};
  assign any_match = chain[QUEUE_DEPTH].found;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_ge;
    if (i == 0) begin : g_head
      assign left_ent = EMPTY_ENTRY;
      assign left_ge  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_ge  = stat[i-1].ge;
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = EMPTY_ENTRY;
    end else begin : g_body
      assign right_ent = ent[i+1];
    end
    spq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .left     (left_ent),
      .left_ge  (left_ge),
      .right    (right_ent),
      .chain_in (chain[i]),
      .ent      (ent[i]),
      .stat     (stat[i]),
      .chain_out(chain[i+1])
    );
  end

  always_comb begin
    extra_any = 1'b0;
    sel_tag   = '0;
    sel_prio  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      extra_any = extra_any | stat[i].extra;
      sel_tag   = sel_tag | stat[i].sel_tag;
      sel_prio  = sel_prio | stat[i].sel_prio;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && req.func == FN_DELETE && !empty && any_match) begin
          state_next = S_PURGE;
        end
      end
      S_PURGE: begin
        if (!extra_any) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '{op: OP_HOLD, tag: req.tag, prio: req.prio};
    cnt_next = cnt;
    wr       = 1'b0;
    res      = '{status: ST_OK, out_tag: '0, out_prio: '0, occupancy: occ_of(cnt)};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          wr = 1'b1;
          unique case (req.func)
            FN_INSERT: begin
              if (full) begin
                res.status = ST_FULL;
              end else begin
                cmd.op        = OP_INSERT;
                cnt_next      = cnt + CNT_W'(1);
                res.occupancy = occ_of(cnt_next);
              end
            end
            FN_DEQUEUE: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else begin
                cmd.op        = OP_DEQUEUE;
                cnt_next      = cnt - CNT_W'(1);
                res.out_tag   = ent[0].tag;
                res.out_prio  = ent[0].prio;
                res.occupancy = occ_of(cnt_next);
              end
            end
            FN_DELETE: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else if (!any_match) begin
                res.status = ST_NOTFOUND;
              end else begin
                cmd.op = OP_MARK;
                wr     = 1'b0;
              end
            end
            FN_FIND: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else if (!any_match) begin
                res.status = ST_NOTFOUND;
              end else begin
                res.out_tag  = sel_tag;
                res.out_prio = sel_prio;
              end
            end
            default: res.status = ST_NOTFOUND;
          endcase
        end
      end
      S_PURGE: begin
        cmd.op        = OP_PURGE;
        cnt_next      = cnt - CNT_W'(1);
        res.occupancy = occ_of(cnt_next);
        wr            = !extra_any;
      end
      default: cmd.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_free) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= wr;
      end else begin
        rsp_valid  <= wr;
        skid_valid <= 1'b0;
      end
    end else begin
      skid_valid <= skid_valid | wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_free) begin
      if (skid_valid) begin
        rsp <= skid;
        if (wr) begin
          skid <= res;
        end
      end else if (wr) begin
        rsp <= res;
      end
    end else if (wr) begin
      skid <= res;
    end
  end

endmodule
